### hw/rtl/etpw_pkg.sv
// Package for the encoder tuner PLL writer: payload structs, frame positions,
// tuning and PLL word constants. No dependencies.

package etpw_pkg;

  localparam int FREQ_W = 11;
  localparam int WORD_W = 15;
  localparam int SCALED_W = 28;
  localparam int PLL_SHIFT = 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FREQ_W-1:0] FREQ_MAX = 11'd2047;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 11'd1020;
  localparam logic [16:0] TENTH_SCALE = 17'd100000;
  localparam logic [SCALED_W-1:0] PLL_OFFSET = 28'd225000;

  localparam logic [7:0] ADDR_RESET = 8'hC0;
  localparam logic [7:0] CTRL3_RESET = 8'hB0;
  localparam logic [7:0] CTRL4_RESET = 8'h10;
  localparam logic [7:0] CTRL5_RESET = 8'h00;

  typedef enum logic [1:0] {
    CFG_TUNER_ADDRESS = 2'd0,
    CFG_CONTROL_THIRD = 2'd1,
    CFG_CONTROL_FOURTH = 2'd2,
    CFG_CONTROL_FIFTH = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    POS_ADDR = 3'd0,
    POS_PLL_HI = 3'd1,
    POS_PLL_LO = 3'd2,
    POS_CTRL3 = 3'd3,
    POS_CTRL4 = 3'd4,
    POS_CTRL5 = 3'd5
  } frame_pos_t;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  typedef struct packed {
    logic op;
    logic a_level;
    logic b_level;
    logic button_pressed;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_value;
    logic last;
  } out_item_t;

endpackage

### hw/rtl/encoder_tuner_pll_writer.sv
// Top level of the encoder tuner PLL writer: front end, word queue, frame
// serialiser. Uses etpw_pkg, etpw_front, etpw_queue, etpw_back.
//
// Takes one encoder edge or button poll per cycle while in_ready is high.
// Edges update direction and the frequency (tenths of a MHz, saturating at 0
// and 2047) and arm the block; a poll with the button pressed while armed
// computes the PLL word in the same cycle and queues it, then the serialiser
// sends address, PLL high, PLL low and three control bytes at one byte per
// cycle while out_ready is high, last set on the sixth. Frames follow back
// to back. Four frames may wait in the queue; in_ready drops while it is
// full. Configuration writes are taken in any cycle.

module encoder_tuner_pll_writer import etpw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic              q_full;
  logic              push;
  logic [WORD_W-1:0] push_word;
  logic              pop;
  logic              q_valid;
  logic [WORD_W-1:0] q_word;

  etpw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  etpw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_word  (q_word)
  );

  etpw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### hw/rtl/etpw_front.sv
// Front end: accepts items, tracks encoder direction, frequency and arm flag,
// and pushes the PLL word of each committing poll. Uses etpw_pkg.

module etpw_front import etpw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  input  logic              q_full,
  output logic              push,
  output logic [WORD_W-1:0] push_word
);

  logic [FREQ_W-1:0]   freq_tenths;
  logic [FREQ_W-1:0]   freq_tenths_next;
  logic                direction;
  logic                direction_next;
  logic                armed;
  logic                armed_next;
  logic                accept;
  logic [SCALED_W-1:0] scaled;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  assign scaled = SCALED_W'(freq_tenths) * SCALED_W'(TENTH_SCALE) + PLL_OFFSET;
  assign push_word = scaled[PLL_SHIFT +: WORD_W];
  assign push = accept && (in_item.op == OP_POLL) && in_item.button_pressed && armed;

  always_comb begin
    freq_tenths_next = freq_tenths;
    direction_next = direction;
    armed_next = armed;
    if (accept) begin
      if (in_item.op == OP_EDGE) begin
        armed_next = 1'b1;
        if (!in_item.a_level) begin
          direction_next = in_item.b_level;
        end else if (in_item.b_level != direction) begin
          if (direction) begin
            if (freq_tenths != '0) freq_tenths_next = freq_tenths - 1'b1;
          end else begin
            if (freq_tenths != FREQ_MAX) freq_tenths_next = freq_tenths + 1'b1;
          end
        end
      end else if (push) begin
        armed_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_tenths <= FREQ_RESET;
      direction <= 1'b0;
      armed <= 1'b1;
    end else begin
      freq_tenths <= freq_tenths_next;
      direction <= direction_next;
      armed <= armed_next;
    end
  end

endmodule

### hw/rtl/etpw_queue.sv
// Short queue of PLL words between front and back end. Uses etpw_pkg.

module etpw_queue import etpw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [WORD_W-1:0] push_word,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output logic [WORD_W-1:0] pop_word
);

  logic [WORD_W-1:0] mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_word = mem[rd_ptr];
  assign do_pop = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/etpw_back.sv
// Back end: holds the configuration registers and serialises each queued
// PLL word into the six-byte frame through an output register. Uses etpw_pkg.

module etpw_back import etpw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              q_valid,
  input  logic [WORD_W-1:0] q_word,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item
);

  logic [7:0]        tuner_address;
  logic [7:0]        control_third;
  logic [7:0]        control_fourth;
  logic [7:0]        control_fifth;
  logic              busy;
  frame_pos_t        pos;
  logic [WORD_W-1:0] word;
  logic              load;
  logic              emit;
  logic              frame_end;
  logic [7:0]        byte_sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tuner_address <= ADDR_RESET;
      control_third <= CTRL3_RESET;
      control_fourth <= CTRL4_RESET;
      control_fifth <= CTRL5_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TUNER_ADDRESS: tuner_address <= cfg_data;
        CFG_CONTROL_THIRD: control_third <= cfg_data;
        CFG_CONTROL_FOURTH: control_fourth <= cfg_data;
        CFG_CONTROL_FIFTH: control_fifth <= cfg_data;
        default: ;
      endcase
    end
  end

  assign load = !out_valid || out_ready;
  assign emit = busy && load;
  assign frame_end = emit && (pos == POS_CTRL5);
  assign pop = q_valid && (!busy || frame_end);

  always_comb begin
    unique case (pos)
      POS_ADDR: byte_sel = tuner_address;
      POS_PLL_HI: byte_sel = 8'(word[WORD_W-1:8]);
      POS_PLL_LO: byte_sel = word[7:0];
      POS_CTRL3: byte_sel = control_third;
      POS_CTRL4: byte_sel = control_fourth;
      POS_CTRL5: byte_sel = control_fifth;
      default: byte_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) word <= q_word;
    if (emit) begin
      out_item.frame_value <= byte_sel;
      out_item.last <= (pos == POS_CTRL5);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos <= POS_ADDR;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        pos <= POS_ADDR;
      end else if (frame_end) begin
        busy <= 1'b0;
        pos <= POS_ADDR;
      end else if (emit) begin
        pos <= frame_pos_t'(pos + 3'd1);
      end
    end
  end

endmodule

### hw/rtl/etpw_checker.sv
// Port-level checker for encoder_tuner_pll_writer, bound to the top level.
// Uses etpw_pkg.

module etpw_checker import etpw_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item,
  input logic      cfg_valid,
  input logic      cfg_ready
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input transaction changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output transaction changed while stalled");

  a_no_double_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_item.last |=> !(out_valid && out_item.last))
    else $error("two frame ends in a row");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("output valid straight after reset");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind encoder_tuner_pll_writer etpw_checker u_etpw_checker (.*);
